// ===== design/lcw80_pkg.sv =====
`timescale 1ns / 1ps

package lcw80_pkg;

  // item kinds
  localparam logic OP_FEED    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // parse phases
  localparam logic [2:0] PH_CMD = 3'd0;
  localparam logic [2:0] PH_OP1 = 3'd1;
  localparam logic [2:0] PH_OP2 = 3'd2;
  localparam logic [2:0] PH_OP3 = 3'd3;
  localparam logic [2:0] PH_OP4 = 3'd4;
  localparam logic [2:0] PH_LIT = 3'd5;
  localparam logic [2:0] PH_RUN = 3'd6;

  // command kinds
  localparam logic [2:0] K_REL  = 3'd0;
  localparam logic [2:0] K_LIT  = 3'd1;
  localparam logic [2:0] K_ABS  = 3'd2;
  localparam logic [2:0] K_FILL = 3'd3;
  localparam logic [2:0] K_LONG = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_WRONG_OP = 2'd1;
  localparam logic [1:0] ERR_UNWRITTEN = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // command byte fields
  localparam logic [5:0] CNT_FILL = 6'h3e;
  localparam logic [5:0] CNT_LONG = 6'h3f;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } lcw80_in_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [15:0] out_index;
    logic        need_byte;
    logic        finished;
    logic [1:0]  error;
  } lcw80_out_t;

endpackage

// ===== design/lcw80_ram.sv =====
`timescale 1ns / 1ps

module lcw80_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lcw_format80_decompressor.sv =====
`timescale 1ns / 1ps
// channel | signals                          | direction | payload
// cmd     | cmd_valid, cmd_ready, cmd_data   | in        | lcw80_in_t (op, in_byte)
// res     | res_valid, res_ready, res_data   | out       | lcw80_out_t (one per cmd item)
//
// A new item can be taken in each cycle unless both result slots are full. The
// history memory is read every cycle at the copy source that the next item
// will use and written at most once per cycle, so the single read port and
// single write port set the rate. Reset is synchronous and clears only the
// parser state and the result buffers; the history memory is not cleared.
// Two result slots (output register and skid register) let the block take
// an item while a result is stalled; cmd_ready drops only when both are full.

module lcw_format80_decompressor #(
  parameter int OUT_SIZE = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  lcw80_pkg::lcw80_in_t   cmd_data,
  output logic                   res_valid,
  input  logic                   res_ready,
  output lcw80_pkg::lcw80_out_t  res_data
);

  localparam int HIST_AW = $clog2(OUT_SIZE);
  localparam logic [16:0] OUT_LIMIT = 17'(OUT_SIZE);

  // parser state
  logic [2:0]  phase, phase_next;
  logic [2:0]  kind, kind_next;
  logic [15:0] operand, operand_next;
  logic [15:0] run_rem, run_rem_next;
  logic [15:0] src_pos, src_pos_next;
  logic [7:0]  fill_val, fill_val_next;
  logic [16:0] wr_pos, wr_pos_next;
  logic        done, done_next;

  // history memory access
  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr;
  logic [7:0]         hist_wdata;
  logic [HIST_AW-1:0] hist_raddr;
  logic [7:0]         hist_rdata;
  logic               fwd_hit;
  logic [7:0]         fwd_data;
  logic [7:0]         src_byte;

  // result buffers
  lcw80_pkg::lcw80_out_t res, out_reg, skid_reg;
  logic                  out_v, skid_v;

  logic       accept;
  logic       out_free;
  logic       op;
  logic [7:0] b;
  logic       want_run;
  logic       wr_full;
  logic       src_bad;
  logic       valid;
  logic [7:0] obyte;
  logic [1:0] err;

  assign op       = cmd_data.op;
  assign b        = cmd_data.in_byte;
  assign cmd_ready = !skid_v;
  assign accept   = cmd_valid && cmd_ready;
  assign want_run = (phase == lcw80_pkg::PH_RUN);
  assign wr_full  = (wr_pos >= OUT_LIMIT);
  assign src_bad  = ({1'b0, src_pos} >= wr_pos);

  // history byte at src_pos, with forwarding of a same-cycle write
  assign src_byte = fwd_hit ? fwd_data : hist_rdata;

  // one item of the parser
  always_comb begin
    phase_next    = phase;
    kind_next     = kind;
    operand_next  = operand;
    run_rem_next  = run_rem;
    src_pos_next  = src_pos;
    fill_val_next = fill_val;
    wr_pos_next   = wr_pos;
    done_next     = done;
    valid         = 1'b0;
    obyte         = 8'd0;
    err           = lcw80_pkg::ERR_NONE;

    if (done || (op == lcw80_pkg::OP_ADVANCE && !want_run) ||
        (op == lcw80_pkg::OP_FEED && want_run)) begin
      err = lcw80_pkg::ERR_WRONG_OP;
    end else if (op == lcw80_pkg::OP_ADVANCE) begin
      // drain one byte of a pending run
      if (wr_full) begin
        err          = lcw80_pkg::ERR_OVERFLOW;
        src_pos_next = src_pos + 16'd1;
        run_rem_next = run_rem - 16'd1;
        if (run_rem_next == 16'd0) begin
          phase_next = lcw80_pkg::PH_CMD;
        end
      end else if (kind == lcw80_pkg::K_FILL) begin
        obyte = fill_val;
        valid = 1'b1;
      end else if (src_bad) begin
        err          = lcw80_pkg::ERR_UNWRITTEN;
        run_rem_next = 16'd0;
        phase_next   = lcw80_pkg::PH_CMD;
      end else begin
        obyte        = src_byte;
        src_pos_next = src_pos + 16'd1;
        valid        = 1'b1;
      end
      if (valid) begin
        wr_pos_next  = wr_pos + 17'd1;
        run_rem_next = run_rem - 16'd1;
        if (run_rem_next == 16'd0) begin
          phase_next = lcw80_pkg::PH_CMD;
        end
      end
    end else begin
      case (phase)
        lcw80_pkg::PH_CMD: begin
          if (!b[7]) begin
            kind_next    = lcw80_pkg::K_REL;
            run_rem_next = 16'(b[6:4]) + 16'd3;
            operand_next = {4'd0, b[3:0], 8'd0};
            phase_next   = lcw80_pkg::PH_OP1;
          end else if (!b[6]) begin
            kind_next    = lcw80_pkg::K_LIT;
            run_rem_next = 16'(b[5:0]);
            if (b[5:0] == 6'd0) begin
              done_next = 1'b1;
            end else begin
              phase_next = lcw80_pkg::PH_LIT;
            end
          end else if (b[5:0] < lcw80_pkg::CNT_FILL) begin
            kind_next    = lcw80_pkg::K_ABS;
            run_rem_next = 16'(b[5:0]) + 16'd3;
            phase_next   = lcw80_pkg::PH_OP1;
          end else begin
            kind_next  = (b[5:0] == lcw80_pkg::CNT_FILL) ? lcw80_pkg::K_FILL
                                                         : lcw80_pkg::K_LONG;
            phase_next = lcw80_pkg::PH_OP1;
          end
        end
        lcw80_pkg::PH_OP1: begin
          if (kind == lcw80_pkg::K_REL) begin
            src_pos_next = wr_pos[15:0] - (operand | {8'd0, b});
            phase_next   = lcw80_pkg::PH_RUN;
          end else begin
            operand_next = {8'd0, b};
            phase_next   = lcw80_pkg::PH_OP2;
          end
        end
        lcw80_pkg::PH_OP2: begin
          operand_next = {b, operand[7:0]};
          if (kind == lcw80_pkg::K_ABS) begin
            src_pos_next = operand_next;
            phase_next   = lcw80_pkg::PH_RUN;
          end else begin
            run_rem_next = operand_next;
            phase_next   = lcw80_pkg::PH_OP3;
          end
        end
        lcw80_pkg::PH_OP3: begin
          if (kind == lcw80_pkg::K_FILL) begin
            fill_val_next = b;
            phase_next    = (run_rem == 16'd0) ? lcw80_pkg::PH_CMD : lcw80_pkg::PH_RUN;
          end else begin
            operand_next = {8'd0, b};
            phase_next   = lcw80_pkg::PH_OP4;
          end
        end
        lcw80_pkg::PH_OP4: begin
          src_pos_next = {b, operand[7:0]};
          phase_next   = (run_rem == 16'd0) ? lcw80_pkg::PH_CMD : lcw80_pkg::PH_RUN;
        end
        lcw80_pkg::PH_LIT: begin
          if (wr_full) begin
            err = lcw80_pkg::ERR_OVERFLOW;
          end else begin
            obyte       = b;
            valid       = 1'b1;
            wr_pos_next = wr_pos + 17'd1;
          end
          run_rem_next = run_rem - 16'd1;
          if (run_rem_next == 16'd0) begin
            phase_next = lcw80_pkg::PH_CMD;
          end
        end
        default: begin
          phase_next = lcw80_pkg::PH_CMD;
        end
      endcase
    end
  end

  // result of this item
  always_comb begin
    res.out_valid = valid;
    res.out_byte  = obyte;
    res.out_index = valid ? wr_pos[15:0] : 16'd0;
    res.need_byte = !done_next && (phase_next != lcw80_pkg::PH_RUN);
    res.finished  = done_next;
    res.error     = err;
  end

  // history write of each produced byte; read of the next copy source
  assign hist_we    = accept && valid;
  assign hist_waddr = wr_pos[HIST_AW-1:0];
  assign hist_wdata = obyte;
  assign hist_raddr = accept ? src_pos_next[HIST_AW-1:0] : src_pos[HIST_AW-1:0];

  lcw80_ram #(
    .WIDTH(8),
    .DEPTH(OUT_SIZE)
  ) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .raddr(hist_raddr),
    .rdata(hist_rdata)
  );

  // forward a write that collides with the read in the same cycle
  always_ff @(posedge clk) begin
    fwd_hit  <= hist_we && (hist_waddr == hist_raddr);
    fwd_data <= hist_wdata;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= lcw80_pkg::PH_CMD;
      kind     <= lcw80_pkg::K_REL;
      operand  <= 16'd0;
      run_rem  <= 16'd0;
      src_pos  <= 16'd0;
      fill_val <= 8'd0;
      wr_pos   <= 17'd0;
      done     <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      kind     <= kind_next;
      operand  <= operand_next;
      run_rem  <= run_rem_next;
      src_pos  <= src_pos_next;
      fill_val <= fill_val_next;
      wr_pos   <= wr_pos_next;
      done     <= done_next;
    end
  end

  // output register with skid slot
  assign out_free = !out_v || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_free) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= accept;
      end else begin
        out_v  <= accept;
      end
    end else if (accept) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v) begin
        out_reg <= skid_reg;
        if (accept) begin
          skid_reg <= res;
        end
      end else if (accept) begin
        out_reg <= res;
      end
    end else if (accept) begin
      skid_reg <= res;
    end
  end

  assign res_valid = out_v;
  assign res_data  = out_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lcw80_pkg::*;

  localparam int IMAGE_SIZE  = 65536;
  localparam int RANDOM_ITEMS = 1450;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 16;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 120;
  localparam logic [7:0] END_CODE = 8'h80;
  localparam logic [16:0] IMAGE_END = 17'(IMAGE_SIZE);

  typedef struct {
    lcw80_in_t item;
    bit        pause;
  } stream_entry_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_ready;
  lcw80_in_t  cmd_data = '0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  lcw80_out_t res_data;

  lcw_format80_decompressor #(.OUT_SIZE(IMAGE_SIZE)) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data(cmd_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder shadow state
  logic [2:0]  phase;
  logic [2:0]  cmd_kind;
  logic [15:0] operand;
  logic [15:0] run_left;
  logic [15:0] src_pos;
  logic [7:0]  fill_byte;
  logic [16:0] wr_pos;
  logic        stream_done;
  logic [7:0]  history [0:IMAGE_SIZE-1];

  stream_entry_t stream_q[$];
  lcw80_out_t    decoded_q[$];

  // stream builder bookkeeping
  int gen_wp = 0;
  int n_gen = 0;
  int n_total = 0;
  bit noisy = 1'b0;
  bit pause_next = 1'b0;

  int n_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int tx_gap = 0, tx_stretch = 0;
  int rx_wait = 0, rx_hold = 0, rx_stretch = 0;
  bit tx_calm = 1'b0, rx_calm = 1'b0;

  // decode one item against the shadow state, returns the result it causes
  function automatic lcw80_out_t lcw_decode(lcw80_in_t it);
    lcw80_out_t r;
    logic [7:0] b;
    logic       in_run;
    r = '0;
    b = it.in_byte;
    in_run = (phase == PH_RUN);
    if (stream_done || (it.op == OP_ADVANCE && !in_run) || (it.op == OP_FEED && in_run)) begin
      r.error = ERR_WRONG_OP;
    end else if (it.op == OP_ADVANCE) begin
      if (wr_pos >= IMAGE_END) begin
        // byte discarded, the run still counts down
        r.error = ERR_OVERFLOW;
        src_pos = src_pos + 16'd1;
        run_left = run_left - 16'd1;
        if (run_left == 16'd0) phase = PH_CMD;
      end else if (cmd_kind == K_FILL) begin
        r.out_valid = 1'b1;
        r.out_byte = fill_byte;
      end else if ({1'b0, src_pos} >= wr_pos) begin
        // source never written: drop the rest of the copy
        r.error = ERR_UNWRITTEN;
        run_left = 16'd0;
        phase = PH_CMD;
      end else begin
        r.out_valid = 1'b1;
        r.out_byte = history[src_pos];
        src_pos = src_pos + 16'd1;
      end
      if (r.out_valid) begin
        r.out_index = wr_pos[15:0];
        history[wr_pos[15:0]] = r.out_byte;
        wr_pos = wr_pos + 17'd1;
        run_left = run_left - 16'd1;
        if (run_left == 16'd0) phase = PH_CMD;
      end
    end else begin
      case (phase)
        PH_CMD: begin
          if (!b[7]) begin
            cmd_kind = K_REL;
            run_left = b[6:4] + 16'd3;
            operand = {4'd0, b[3:0], 8'd0};
            phase = PH_OP1;
          end else if (!b[6]) begin
            cmd_kind = K_LIT;
            run_left = {10'd0, b[5:0]};
            if (run_left == 16'd0) stream_done = 1'b1;
            else phase = PH_LIT;
          end else if (b[5:0] < CNT_FILL) begin
            cmd_kind = K_ABS;
            run_left = b[5:0] + 16'd3;
            phase = PH_OP1;
          end else begin
            cmd_kind = (b[5:0] == CNT_FILL) ? K_FILL : K_LONG;
            phase = PH_OP1;
          end
        end
        PH_OP1: begin
          if (cmd_kind == K_REL) begin
            src_pos = wr_pos[15:0] - (operand | {8'd0, b});
            phase = PH_RUN;
          end else begin
            operand = {8'd0, b};
            phase = PH_OP2;
          end
        end
        PH_OP2: begin
          operand[15:8] = b;
          if (cmd_kind == K_ABS) begin
            src_pos = operand;
            phase = PH_RUN;
          end else begin
            run_left = operand;
            phase = PH_OP3;
          end
        end
        PH_OP3: begin
          if (cmd_kind == K_FILL) begin
            fill_byte = b;
            phase = (run_left == 16'd0) ? PH_CMD : PH_RUN;
          end else begin
            operand = {8'd0, b};
            phase = PH_OP4;
          end
        end
        PH_OP4: begin
          src_pos = {b, operand[7:0]};
          phase = (run_left == 16'd0) ? PH_CMD : PH_RUN;
        end
        PH_LIT: begin
          if (wr_pos >= IMAGE_END) begin
            r.error = ERR_OVERFLOW;
          end else begin
            r.out_valid = 1'b1;
            r.out_byte = b;
            r.out_index = wr_pos[15:0];
            history[wr_pos[15:0]] = b;
            wr_pos = wr_pos + 17'd1;
          end
          run_left = run_left - 16'd1;
          if (run_left == 16'd0) phase = PH_CMD;
        end
        default: begin
          phase = PH_CMD;
        end
      endcase
    end
    r.need_byte = !stream_done && phase != PH_RUN;
    r.finished = stream_done;
    return r;
  endfunction

  // idle cycles before the next transfer, with stretches of no idling
  function automatic int draw_gap(inout int stretch, inout bit calm);
    if (stretch == 0) begin
      stretch = $urandom_range(8, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    stretch--;
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // stream building
  task automatic put(logic op, logic [7:0] b);
    stream_entry_t e;
    e.item.op = op;
    e.item.in_byte = b;
    e.pause = pause_next;
    pause_next = 1'b0;
    stream_q.push_back(e);
  endtask

  task automatic feed(logic [7:0] b);
    if (noisy && $urandom_range(0, 99) < 3) put(OP_ADVANCE, 8'($urandom_range(0, 255)));
    put(OP_FEED, b);
    n_gen++;
  endtask

  task automatic advance(int n);
    repeat (n) begin
      if (noisy && $urandom_range(0, 99) < 3) put(OP_FEED, 8'($urandom_range(0, 255)));
      put(OP_ADVANCE, 8'($urandom_range(0, 255)));
      n_gen++;
    end
  endtask

  task automatic cmd_rel(logic [2:0] c, logic [11:0] off);
    feed({1'b0, c, off[11:8]});
    feed(off[7:0]);
  endtask

  task automatic cmd_lit(int n);
    feed({2'b10, 6'(n)});
    repeat (n) feed(8'($urandom_range(0, 255)));
  endtask

  task automatic cmd_abs(logic [5:0] c, logic [15:0] src);
    feed({2'b11, c});
    feed(src[7:0]);
    feed(src[15:8]);
  endtask

  task automatic cmd_fill(logic [15:0] cnt, logic [7:0] v);
    feed({2'b11, CNT_FILL});
    feed(cnt[7:0]);
    feed(cnt[15:8]);
    feed(v);
  endtask

  task automatic cmd_long(logic [15:0] cnt, logic [15:0] src);
    feed({2'b11, CNT_LONG});
    feed(cnt[7:0]);
    feed(cnt[15:8]);
    feed(src[7:0]);
    feed(src[15:8]);
  endtask

  // driver: one transfer per item, prediction at acceptance
  always @(posedge clk) begin : driver
    stream_entry_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd_data <= '0;
      tx_gap <= 0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        decoded_q.push_back(lcw_decode(cmd_data));
        n_accepted++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          cmd_valid <= 1'b0;
        end else if (stream_q.size() != 0 && !(stream_q[0].pause && decoded_q.size() != 0)) begin
          nxt = stream_q.pop_front();
          cmd_data <= nxt.item;
          cmd_valid <= 1'b1;
          tx_gap <= draw_gap(tx_stretch, tx_calm);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin : monitor
    lcw80_out_t want;
    int wait_n;
    int hold_n;
    if (rst) begin
      res_ready <= 1'b0;
      rx_wait <= 0;
      rx_hold <= 0;
    end else begin
      wait_n = rx_wait;
      hold_n = rx_hold;
      if (res_valid && res_ready) begin
        if (decoded_q.size() == 0) begin
          $error("result transfer with no prediction pending");
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_valid", 16'(want.out_valid), 16'(res_data.out_valid));
          check_field("out_byte", 16'(want.out_byte), 16'(res_data.out_byte));
          check_field("out_index", want.out_index, res_data.out_index);
          check_field("need_byte", 16'(want.need_byte), 16'(res_data.need_byte));
          check_field("finished", 16'(want.finished), 16'(res_data.finished));
          check_field("error", 16'(want.error), 16'(res_data.error));
        end
        results_seen++;
        // one long back-pressure stretch so the input side stalls
        if (results_seen == HOLD_AFTER) hold_n = HOLD_CYCLES;
        wait_n = draw_gap(rx_stretch, rx_calm);
      end
      if (hold_n > 0) begin
        hold_n--;
        res_ready <= 1'b0;
      end else if (wait_n > 0) begin
        wait_n--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
      rx_wait <= wait_n;
      rx_hold <= hold_n;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int pick, c, off, cnt;
    bit timed_out;
    timed_out = 1'b0;

    // shadow state after reset
    phase = PH_CMD;
    cmd_kind = K_REL;
    operand = '0;
    run_left = '0;
    src_pos = '0;
    fill_byte = '0;
    wr_pos = '0;
    stream_done = 1'b0;

    // directed: wrong ops, reference before the start, zero counts, overlap
    put(OP_ADVANCE, 8'h00);
    cmd_rel(3'd0, 12'd1);
    advance(2);
    feed({2'b10, 6'd2});
    feed(8'h00);
    put(OP_ADVANCE, 8'hff);
    feed(8'hff);
    gen_wp = 2;
    cmd_fill(16'd0, 8'h77);
    cmd_fill(16'd2, 8'ha5);
    put(OP_FEED, 8'h12);
    advance(2);
    gen_wp += 2;
    cmd_rel(3'd0, 12'd1);
    advance(3);
    gen_wp += 3;
    cmd_long(16'd0, 16'd0);

    // random well-formed commands with some broken references and stray items
    noisy = 1'b1;
    pause_next = 1'b1;
    while (n_gen < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 20 || gen_wp == 0) begin
        cnt = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(1, 20);
        cmd_lit(cnt);
        gen_wp += cnt;
      end else if (pick < 38) begin
        c = $urandom_range(0, 7);
        off = (gen_wp < 4095) ? gen_wp : 4095;
        if ($urandom_range(0, 3) != 0) off = $urandom_range(1, off);
        cmd_rel(3'(c), 12'(off));
        advance(c + 3);
        gen_wp += c + 3;
      end else if (pick < 52) begin
        c = ($urandom_range(0, 5) == 0) ? CNT_FILL - 1 : $urandom_range(0, 12);
        cmd_abs(6'(c), 16'($urandom_range(0, gen_wp - 1)));
        advance(c + 3);
        gen_wp += c + 3;
      end else if (pick < 66) begin
        cnt = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
        cmd_fill(16'(cnt), 8'($urandom_range(0, 255)));
        advance(cnt);
        gen_wp += cnt;
      end else if (pick < 78) begin
        cnt = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
        cmd_long(16'(cnt), 16'($urandom_range(0, gen_wp - 1)));
        advance(cnt);
        gen_wp += cnt;
      end else if (pick < 90) begin
        // copy from a position not yet written: fails on its first byte
        case ($urandom_range(0, 2))
          0: begin
            off = (gen_wp < 4095 && $urandom_range(0, 1) == 1) ?
                  $urandom_range(gen_wp + 1, 4095) : 0;
            cmd_rel(3'($urandom_range(0, 7)), 12'(off));
          end
          1: cmd_abs(6'($urandom_range(0, CNT_FILL - 1)),
                     16'($urandom_range(gen_wp, 65535)));
          default: cmd_long(16'($urandom_range(1, 24)),
                            16'($urandom_range(gen_wp, 65535)));
        endcase
        advance(1);
      end else begin
        repeat ($urandom_range(1, 3)) put(OP_ADVANCE, 8'($urandom_range(0, 255)));
      end
    end

    // a few plain commands after a pause
    noisy = 1'b0;
    pause_next = 1'b1;
    feed({2'b10, 6'd2});
    feed(8'h3c);
    feed(8'hc3);
    cmd_abs(6'd0, 16'd0);
    advance(3);
    cmd_rel(3'd0, 12'd1);
    advance(3);

    // end of stream, then items after the end
    feed(END_CODE);
    put(OP_FEED, 8'h55);
    put(OP_ADVANCE, 8'haa);
    n_total = stream_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (!timed_out && (n_accepted != n_total || decoded_q.size() != 0)) begin
      @(posedge clk);
      if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
    end
    if (timed_out) begin
      $error("no transfer for %0d cycles, %0d of %0d items accepted, %0d results pending",
             QUIET_LIMIT, n_accepted, n_total, decoded_q.size());
    end else begin
      repeat (SETTLE) @(posedge clk);
    end

    if (timed_out) begin
      $display("[lcw_format80_decompressor] ERROR");
    end else if (mismatches == 0) begin
      $display("[lcw_format80_decompressor] OK");
    end else begin
      $display("[lcw_format80_decompressor] ERROR");
    end
    $finish;
  end

endmodule
